// File: rtl/bcel_pkg.sv
// ----------------------------------------------------------------------------
// bcel_pkg
// Shared types, constants and the softplus table function for the
// binary cross-entropy with logits loss block.
// ----------------------------------------------------------------------------
package bcel_pkg;

   // Default sizes
   localparam int SOFTPLUS_ENTRIES_DEF = 256;
   localparam int COUNT_BITS_DEF       = 21;

   // Field widths
   localparam int X_W     = 16;   // logit, weights, Q3.12
   localparam int Y_W     = 13;   // target, Q1.12
   localparam int LOSS_W  = 48;   // loss, Q35.12
   localparam int SP_W    = 12;   // softplus table entry, Q0.12
   localparam int REQ_W   = 64;   // packed request data
   localparam int USER_W  = 2;

   // Configuration port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // Register indexes
   localparam logic [1:0] REG_MODE   = 2'd0;
   localparam logic [1:0] REG_WEIGHT = 2'd1;
   localparam logic [1:0] REG_POSW   = 2'd2;

   // Reduction modes
   localparam logic [1:0] MODE_NONE = 2'd0;
   localparam logic [1:0] MODE_MEAN = 2'd1;

   // Fixed-point one in Q12
   localparam int ONE_Q12 = 4096;

   typedef struct packed {
      logic [1:0] mode;
      logic       weight_present;
      logic       pos_weight_present;
   } cfg_type;

   typedef struct packed {
      logic cap;
      logic acc;
      logic emit_elem;
      logic div_init;
      logic div_step;
      logic emit_red;
   } cmd_type;

   typedef struct packed {
      logic mode_none;
      logic mode_mean;
      logic last;
      logic div_done;
      logic out_free;
   } status_type;

   // Unsigned 64-bit quotient by shift and subtract; elaboration only
   function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
      logic [63:0] q;
      logic [64:0] r;
      q = '0;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         r = {r[63:0], n[b]};
         if (r >= {1'b0, d}) begin
            r    = r - {1'b0, d};
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   // ln(1+exp(-t)) for t in Q30 (0..8), result in Q12; elaboration only
   function automatic logic [SP_W-1:0] softplus_at(input logic [63:0] t);
      logic [63:0] u, term, ex, e, z, z2, p, acc, ln, r;
      u    = t >> 4;
      term = 64'd1 << 30;
      ex   = 64'd1 << 30;
      for (int k = 1; k <= 20; k++) begin
         term = (term * u) >> 30;
         term = udiv64(term, 64'(k));
         ex   = ex + term;
      end
      e = udiv64(64'd1 << 60, ex);
      for (int k = 0; k < 4; k++) begin
         e = (e * e) >> 30;
      end
      z   = udiv64(e << 30, (64'd1 << 31) + e);
      z2  = (z * z) >> 30;
      p   = z;
      acc = 64'd0;
      for (int k = 0; k < 20; k++) begin
         acc = acc + udiv64(p, 64'(2 * k + 1));
         p   = (p * z2) >> 30;
      end
      ln = acc << 1;
      r  = (ln + (64'd1 << 17)) >> 18;
      return r[SP_W-1:0];
   endfunction

endpackage

// File: rtl/bcel_csr.sv
// ----------------------------------------------------------------------------
// bcel_csr
// APB-style register file: reduction mode and the two weight-present flags.
// ----------------------------------------------------------------------------
module bcel_csr
   import bcel_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   logic [1:0] mode_ff, mode_in;
   logic       wp_ff, wp_in;
   logic       pwp_ff, pwp_in;
   logic       wr_en;
   logic [1:0] reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign reg_idx    = csr_paddr[3:2];

   // Decode register writes
   always_comb begin
      mode_in = mode_ff;
      wp_in   = wp_ff;
      pwp_in  = pwp_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_MODE:   mode_in = csr_pwdata[1:0];
            REG_WEIGHT: wp_in   = csr_pwdata[0];
            REG_POSW:   pwp_in  = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_NONE;
         wp_ff   <= 1'b0;
         pwp_ff  <= 1'b0;
      end else begin
         mode_ff <= mode_in;
         wp_ff   <= wp_in;
         pwp_ff  <= pwp_in;
      end
   end

   // Read back
   always_comb begin
      unique case (reg_idx)
         REG_MODE:   csr_prdata = {{(CSR_DATA_W-2){1'b0}}, mode_ff};
         REG_WEIGHT: csr_prdata = {{(CSR_DATA_W-1){1'b0}}, wp_ff};
         REG_POSW:   csr_prdata = {{(CSR_DATA_W-1){1'b0}}, pwp_ff};
         default:    csr_prdata = '0;
      endcase
   end

   assign cfg.mode               = mode_ff;
   assign cfg.weight_present     = wp_ff;
   assign cfg.pos_weight_present = pwp_ff;

endmodule

// File: rtl/bcel_ctrl.sv
// ----------------------------------------------------------------------------
// bcel_ctrl
// Controller: sequences one element through the datapath stages, the
// accumulate step, the mean divider and the result register.
// ----------------------------------------------------------------------------
module bcel_ctrl
   import bcel_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type st,
   output cmd_type    cmd
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_P1    = 4'd1;
   localparam logic [3:0] S_P2    = 4'd2;
   localparam logic [3:0] S_P3    = 4'd3;
   localparam logic [3:0] S_P4    = 4'd4;
   localparam logic [3:0] S_P5    = 4'd5;
   localparam logic [3:0] S_FIN   = 4'd6;
   localparam logic [3:0] S_DINIT = 4'd7;
   localparam logic [3:0] S_DIV   = 4'd8;
   localparam logic [3:0] S_EMIT  = 4'd9;

   logic [3:0] state_ff, state_in;

   assign req_tready = (state_ff == S_IDLE);

   // Next state and commands
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.cap  = 1'b1;
               state_in = S_P1;
            end
         end
         S_P1: state_in = S_P2;
         S_P2: state_in = S_P3;
         S_P3: state_in = S_P4;
         S_P4: state_in = S_P5;
         S_P5: state_in = S_FIN;
         S_FIN: begin
            if (st.mode_none) begin
               if (st.out_free) begin
                  cmd.emit_elem = 1'b1;
                  state_in      = S_IDLE;
               end
            end else begin
               cmd.acc = 1'b1;
               if (!st.last) begin
                  state_in = S_IDLE;
               end else if (st.mode_mean) begin
                  state_in = S_DINIT;
               end else begin
                  state_in = S_EMIT;
               end
            end
         end
         S_DINIT: begin
            cmd.div_init = 1'b1;
            state_in     = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (st.div_done) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (st.out_free) begin
               cmd.emit_red = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef ASSERT_OFF
   // An accepted element reaches the final step after the five stages
   a_stage_timing: assert property (@(posedge clock) disable iff (reset)
      cmd.cap |-> ##6 (state_ff == S_FIN))
      else $error("element did not reach final step in time");
`endif

endmodule

// File: rtl/bcel_dp.sv
// ----------------------------------------------------------------------------
// bcel_dp
// Datapath: input capture, five-stage loss computation, saturating
// accumulator with element count, bit-serial mean divider, result register.
// ----------------------------------------------------------------------------
module bcel_dp
   import bcel_pkg::*;
#(
   parameter int SOFTPLUS_ENTRIES = SOFTPLUS_ENTRIES_DEF,
   parameter int COUNT_BITS       = COUNT_BITS_DEF
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic [REQ_W-1:0]  req_tdata,
   input  logic              req_tlast,
   input  cfg_type           cfg,
   input  cmd_type           cmd,
   output status_type        st,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [LOSS_W-1:0] rsp_tdata,
   output logic [USER_W-1:0] rsp_tuser
);

   localparam int IDX_W     = $clog2(SOFTPLUS_ENTRIES);
   localparam int IDXP_W    = X_W + 1 + $clog2(SOFTPLUS_ENTRIES + 1);
   localparam int T1_W      = 30;
   localparam int LW_W      = 32;
   localparam int SPM_W     = 17;
   localparam int T2_W      = LW_W + SPM_W;
   localparam int BASE_W    = 50;
   localparam int PROD_W    = 64;
   localparam int LQ_W      = 28;
   localparam int NUM_W     = LOSS_W + 1;
   localparam int DIV_STEPS = NUM_W;
   localparam int DCNT_W    = $clog2(DIV_STEPS + 1);

   localparam logic signed [LOSS_W-1:0] SUM_MAX = {1'b0, {(LOSS_W-1){1'b1}}};
   localparam logic signed [LOSS_W-1:0] SUM_MIN = {1'b1, {(LOSS_W-1){1'b0}}};

   // Softplus table
   logic [SP_W-1:0] rom_tab [SOFTPLUS_ENTRIES];
   for (genvar gi = 0; gi < SOFTPLUS_ENTRIES; gi++) begin : g_rom
      localparam logic [63:0] T_Q30 = (64'(2 * gi + 1) << 32) / 64'(SOFTPLUS_ENTRIES);
      localparam logic [SP_W-1:0] SP_VAL = softplus_at(T_Q30);
      assign rom_tab[gi] = SP_VAL;
   end

   // Capture the request
   logic signed [X_W-1:0] x_ff, w_ff, pw_ff;
   logic [Y_W-1:0]        y_ff;
   logic                  last_ff;
   logic [Y_W-1:0]        tgt;

   assign tgt = req_tdata[28:16];

   always_ff @(posedge clock) begin
      if (cmd.cap) begin
         x_ff    <= req_tdata[15:0];
         y_ff    <= (tgt > Y_W'(ONE_Q12)) ? Y_W'(ONE_Q12) : tgt;
         w_ff    <= cfg.weight_present ? req_tdata[44:29] : X_W'(ONE_Q12);
         pw_ff   <= cfg.pos_weight_present ? req_tdata[60:45] : X_W'(ONE_Q12);
         last_ff <= req_tlast;
      end
   end

   // Stage 1: table lookup, (1-y)x and the positive-weight factor
   logic signed [X_W:0]      x17, ax, mv;
   logic signed [Y_W:0]      y14, omy;
   logic signed [X_W:0]      pwm;
   logic [IDXP_W-1:0]        idx_full;
   logic [IDX_W-1:0]         idx;
   logic signed [T1_W-1:0]   t1_in, t1_ff;
   logic signed [LW_W-1:0]   lw_in, lw_ff;
   logic signed [SPM_W-1:0]  spm_in, spm_ff;
   logic signed [X_W-1:0]    w1_ff;

   always_comb begin
      x17      = (X_W+1)'(x_ff);
      ax       = x17[X_W] ? -x17 : x17;
      mv       = x17[X_W] ? ax : '0;
      idx_full = (IDXP_W'(ax) * IDXP_W'(SOFTPLUS_ENTRIES)) >> 15;
      if (idx_full >= IDXP_W'(SOFTPLUS_ENTRIES - 1)) begin
         idx = IDX_W'(SOFTPLUS_ENTRIES - 1);
      end else begin
         idx = idx_full[IDX_W-1:0];
      end
      y14    = $signed({1'b0, y_ff});
      omy    = (Y_W+1)'(ONE_Q12) - y14;
      pwm    = (X_W+1)'(pw_ff) - (X_W+1)'(ONE_Q12);
      t1_in  = T1_W'(x_ff) * T1_W'(omy);
      lw_in  = LW_W'(pwm) * LW_W'(y14) + (LW_W'(1) <<< 24);
      spm_in = $signed(SPM_W'(rom_tab[idx])) + SPM_W'(mv);
   end

   // Stage 2: lw * (softplus + max(-x,0))
   logic signed [T2_W-1:0]   t2_ff;
   logic signed [T1_W-1:0]   t1b_ff;
   logic signed [X_W-1:0]    w2_ff;

   // Stage 3: align and add the two terms
   logic signed [BASE_W-1:0] base_ff;
   logic signed [X_W-1:0]    w3_ff;

   // Stage 4: times the element weight; stage 5: round to Q12
   logic signed [PROD_W-1:0] prod_ff, rnd;
   logic signed [LQ_W-1:0]   loss_ff;

   assign rnd = prod_ff + (PROD_W'(1) <<< 35);

   // Advance the stages
   always_ff @(posedge clock) begin
      t1_ff   <= t1_in;
      lw_ff   <= lw_in;
      spm_ff  <= spm_in;
      w1_ff   <= w_ff;
      t2_ff   <= T2_W'(lw_ff) * T2_W'(spm_ff);
      t1b_ff  <= t1_ff;
      w2_ff   <= w1_ff;
      base_ff <= (BASE_W'(t1b_ff) <<< 12) + BASE_W'(t2_ff);
      w3_ff   <= w2_ff;
      prod_ff <= PROD_W'(base_ff) * PROD_W'(w3_ff);
      loss_ff <= LQ_W'(rnd >>> 36);
   end

   // Accumulator
   logic signed [LOSS_W-1:0] sum_ff, sum_in;
   logic [COUNT_BITS-1:0]    cnt_ff, cnt_in;
   logic                     sat_ff, sat_in;
   logic signed [LOSS_W:0]   sum_wide;

   always_comb begin
      sum_wide = (LOSS_W+1)'(sum_ff) + (LOSS_W+1)'(loss_ff);
      sum_in   = sum_ff;
      cnt_in   = cnt_ff;
      sat_in   = sat_ff;
      if (cmd.emit_red) begin
         sum_in = '0;
         cnt_in = '0;
         sat_in = 1'b0;
      end else if (cmd.acc) begin
         if (!sum_wide[LOSS_W] && sum_wide[LOSS_W-1]) begin
            sum_in = SUM_MAX;
            sat_in = 1'b1;
         end else if (sum_wide[LOSS_W] && !sum_wide[LOSS_W-1]) begin
            sum_in = SUM_MIN;
            sat_in = 1'b1;
         end else begin
            sum_in = sum_wide[LOSS_W-1:0];
         end
         if (&cnt_ff) begin
            sat_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         cnt_ff <= '0;
         sat_ff <= 1'b0;
      end else begin
         sum_ff <= sum_in;
         cnt_ff <= cnt_in;
         sat_ff <= sat_in;
      end
   end

   // Mean divider: restoring, one quotient bit per cycle
   logic [NUM_W-1:0]      num_ff, num_in;
   logic [COUNT_BITS-1:0] rem_ff, rem_in;
   logic [DCNT_W-1:0]     dcnt_ff, dcnt_in;
   logic                  neg_ff;
   logic [LOSS_W-1:0]     mag;
   logic [COUNT_BITS:0]   part, diff;
   logic                  ge;
   logic [LOSS_W-1:0]     quo, mean_val;

   always_comb begin
      mag     = sum_ff[LOSS_W-1] ? LOSS_W'(-sum_ff) : LOSS_W'(sum_ff);
      part    = {rem_ff, num_ff[NUM_W-1]};
      diff    = part - {1'b0, cnt_ff};
      ge      = (part >= {1'b0, cnt_ff});
      num_in  = num_ff;
      rem_in  = rem_ff;
      dcnt_in = dcnt_ff;
      if (cmd.div_init) begin
         num_in  = NUM_W'(mag) + NUM_W'(cnt_ff >> 1);
         rem_in  = '0;
         dcnt_in = DCNT_W'(DIV_STEPS);
      end else if (cmd.div_step) begin
         num_in  = {num_ff[NUM_W-2:0], ge};
         rem_in  = ge ? diff[COUNT_BITS-1:0] : part[COUNT_BITS-1:0];
         dcnt_in = dcnt_ff - 1'b1;
      end
      quo      = num_ff[LOSS_W-1:0];
      mean_val = neg_ff ? -quo : quo;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dcnt_ff <= '0;
      end else begin
         dcnt_ff <= dcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      if (cmd.div_init) begin
         neg_ff <= sum_ff[LOSS_W-1];
      end
   end

   // Result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [LOSS_W-1:0]   rsp_data_ff;
   logic [USER_W-1:0]   rsp_user_ff;
   logic                is_mean;

   assign is_mean = (cfg.mode == MODE_MEAN);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit_elem || cmd.emit_red) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_elem) begin
         rsp_data_ff <= LOSS_W'(loss_ff);
         rsp_user_ff <= 2'b00;
      end else if (cmd.emit_red) begin
         rsp_data_ff <= is_mean ? mean_val : sum_ff;
         rsp_user_ff <= {sat_ff, 1'b1};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // Status to the controller
   assign st.mode_none = (cfg.mode == MODE_NONE);
   assign st.mode_mean = is_mean;
   assign st.last      = last_ff;
   assign st.div_done  = (dcnt_ff == DCNT_W'(1));
   assign st.out_free  = !rsp_valid_ff || rsp_tready;

`ifndef ASSERT_OFF
   // Never overwrite a result that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !(cmd.emit_elem || cmd.emit_red))
      else $error("pending result overwritten");

   // A reduced result leaves the accumulator empty
   a_clear_after_emit: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_red |=> (sum_ff == '0 && cnt_ff == '0 && !sat_ff))
      else $error("accumulator not cleared after run");

   // Divider steps only while bits remain
   a_div_bounded: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> (dcnt_ff != '0))
      else $error("divider stepped past its last bit");
`endif

endmodule

// File: rtl/bce_with_logits_loss.sv
// ----------------------------------------------------------------------------
// bce_with_logits_loss
// Streaming binary cross-entropy with logits, fixed point, with optional
// mean or sum reduction over a run.
// ----------------------------------------------------------------------------
// A new element is taken only once the previous one is through: the capture
// step, five arithmetic stages (table lookup, multiply, add, weight multiply,
// round) and a finish step that writes the result register or the
// accumulator; the controller holds req_tready low until then. In sum mode
// the last element of a run then passes a state that loads the total; in mean
// mode it first passes the bit-serial divider, which produces one of 49
// quotient bits per cycle. A finished result sits in an output register, so
// a new element is accepted while it waits; the block stalls only when a
// second result is ready before the first has been taken. Softplus comes
// from a constant table of SOFTPLUS_ENTRIES entries over |x| in [0, 8).
// ----------------------------------------------------------------------------
module bce_with_logits_loss
   import bcel_pkg::*;
#(
   parameter int SOFTPLUS_ENTRIES = SOFTPLUS_ENTRIES_DEF,
   parameter int COUNT_BITS       = COUNT_BITS_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,
   // logit[15:0], target[28:16], elem_weight[44:29], positive_weight[60:45]
   input  logic [REQ_W-1:0]      req_tdata,
   input  logic                  req_tlast,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // loss[47:0]
   output logic [LOSS_W-1:0]     rsp_tdata,
   // is_reduced[0], saturated[1]
   output logic [USER_W-1:0]     rsp_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type    cfg;
   cmd_type    cmd;
   status_type st;

   bcel_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   bcel_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .st         (st),
      .cmd        (cmd)
   );

   bcel_dp #(
      .SOFTPLUS_ENTRIES (SOFTPLUS_ENTRIES),
      .COUNT_BITS       (COUNT_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .cfg        (cfg),
      .cmd        (cmd),
      .st         (st),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the streaming BCE-with-logits loss block.
// A scoreboard predicts each loss, mean or sum from its own softplus table
// and accumulator copy; directed corner items are followed by random runs
// under random register settings, with random gaps and stalls on both streams.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import bcel_pkg::*;

   localparam int  TABLE_N     = 256;
   localparam int  CNT_BITS    = 21;
   localparam int  IDLE_LIMIT  = 20000;
   localparam int  SETTLE      = 120;
   localparam logic [1:0] MODE_SUM  = 2'd2;
   localparam logic [1:0] MODE_ALT  = 2'd3;
   localparam logic [CSR_ADDR_W-1:0] ADDR_NONE = 4'd12;
   localparam longint SUM_MAX = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint SUM_MIN = -64'sh0000_7FFF_FFFF_FFFF - 1;

   // ------------------------------------------------------------------
   // Scoreboard: predicts results and checks them in order
   // ------------------------------------------------------------------
   class loss_scoreboard;
      logic [1:0]      mode;
      bit              use_w, use_pw;
      longint          run_sum;
      longint unsigned run_count;
      bit              run_sat;
      logic [49:0]     pending[$];
      int              mismatches;
      logic [11:0]     sp_table[TABLE_N];

      // ln(1+exp(-t)), t in Q30, result in Q12
      function automatic logic [11:0] softplus_q12(longint unsigned t);
         longint unsigned u, term, ex, e, z, z2, p, acc;
         u = t >> 4;
         term = 64'd1 << 30;
         ex = term;
         for (int k = 1; k <= 20; k++) begin
            term = ((term * u) >> 30) / k;
            ex += term;
         end
         e = (64'd1 << 60) / ex;
         repeat (4) e = (e * e) >> 30;
         z = (e << 30) / ((64'd1 << 31) + e);
         z2 = (z * z) >> 30;
         p = z;
         acc = 0;
         for (int k = 0; k < 20; k++) begin
            acc += p / (2 * k + 1);
            p = (p * z2) >> 30;
         end
         return 12'(((acc << 1) + (64'd1 << 17)) >> 18);
      endfunction

      function new();
         for (int i = 0; i < TABLE_N; i++) begin
            sp_table[i] = softplus_q12(((64'd2 * i + 1) << 32) / TABLE_N);
         end
         mode = MODE_NONE;
         mismatches = 0;
         run_sum = 0;
         run_count = 0;
         run_sat = 0;
      endfunction

      function void set_reg(logic [CSR_ADDR_W-1:0] addr, logic [31:0] value);
         case (addr[3:2])
            REG_MODE:   mode   = value[1:0];
            REG_WEIGHT: use_w  = value[0];
            REG_POSW:   use_pw = value[0];
            default: ;
         endcase
      endfunction

      // Note an accepted element and queue its result, if any
      function void note_input(logic signed [15:0] lx, logic [12:0] ty,
                               logic signed [15:0] ew, logic signed [15:0] pwt,
                               bit is_last);
         longint x, y, w, pw, ax, mv, t1, lw, t2, loss, res;
         longint unsigned idx, mag, q;
         x = lx;
         y = (ty > ONE_Q12) ? ONE_Q12 : ty;
         w = use_w ? longint'(ew) : ONE_Q12;
         pw = use_pw ? longint'(pwt) : ONE_Q12;
         ax = (x < 0) ? -x : x;
         mv = (x < 0) ? -x : 0;
         idx = (ax * TABLE_N) >> 15;
         if (idx >= TABLE_N) idx = TABLE_N - 1;
         t1 = (ONE_Q12 - y) * x;
         lw = longint'(ONE_Q12) * ONE_Q12 + (pw - ONE_Q12) * y;
         t2 = lw * (longint'(sp_table[idx]) + mv);
         loss = (t1 * ONE_Q12 + t2) * w;
         loss = (loss + (64'sd1 << 35)) >>> 36;
         if (mode == MODE_NONE) begin
            pending.push_back({2'b00, loss[47:0]});
            return;
         end
         // accumulate with saturation
         run_sum += loss;
         if (run_sum > SUM_MAX) begin
            run_sum = SUM_MAX;
            run_sat = 1;
         end else if (run_sum < SUM_MIN) begin
            run_sum = SUM_MIN;
            run_sat = 1;
         end
         if (run_count >= (64'd1 << CNT_BITS) - 1) begin
            run_count = (64'd1 << CNT_BITS) - 1;
            run_sat = 1;
         end else begin
            run_count++;
         end
         if (!is_last) return;
         res = run_sum;
         if (mode == MODE_MEAN) begin
            mag = (res < 0) ? -res : res;
            q = (mag + run_count / 2) / run_count;
            res = (res < 0) ? -longint'(q) : longint'(q);
         end
         pending.push_back({run_sat, 1'b1, res[47:0]});
         run_sum = 0;
         run_count = 0;
         run_sat = 0;
      endfunction

      // Compare one result transaction with the oldest expectation
      function void compare_result(logic [47:0] loss, logic [1:0] flags);
         logic [49:0] want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: loss=%h flags=%b", loss, flags);
            return;
         end
         want = pending.pop_front();
         if (want != {flags, loss}) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected loss=%h sat=%b red=%b, got loss=%h sat=%b red=%b",
                        want[47:0], want[49], want[48], loss, flags[1], flags[0]);
         end
      endfunction
   endclass

   // ------------------------------------------------------------------
   // Signals and DUT
   // ------------------------------------------------------------------
   logic clock = 0;
   logic reset = 1;
   logic [REQ_W-1:0]      req_tdata = '0;
   logic                  req_tlast = 0;
   logic                  req_tvalid = 0;
   logic                  req_tready;
   logic [LOSS_W-1:0]     rsp_tdata;
   logic [USER_W-1:0]     rsp_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 0;
   logic                  csr_psel = 0;
   logic                  csr_penable = 0;
   logic                  csr_pwrite = 0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   loss_scoreboard sb = new();
   int  hold_cycles = 0;   // receiver hold-off request
   bit  no_gaps = 0;       // sender runs back to back
   bit  no_stalls = 0;     // receiver always ready
   int  idle_count = 0;

   bce_with_logits_loss uut (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Receiver: random stalls plus requested long hold-offs
   // ------------------------------------------------------------------
   int stall_left = 0;
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         rsp_tready <= 0;
         hold_cycles <= hold_cycles - 1;
      end else if (stall_left > 0) begin
         rsp_tready <= 0;
         stall_left <= stall_left - 1;
      end else if (!no_stalls && $urandom_range(0, 5) == 0) begin
         rsp_tready <= 0;
         stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(0, 3);
      end else begin
         rsp_tready <= 1;
      end
   end

   // Check results and watch for a hung run
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.compare_result(rsp_tdata, rsp_tuser);
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel)
         idle_count <= 0;
      else
         idle_count <= idle_count + 1;
      if (idle_count >= IDLE_LIMIT) begin
         $display("FAIL bce_with_logits_loss");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Driver tasks
   // ------------------------------------------------------------------
   task automatic send_item(logic [15:0] lx, logic [12:0] ty, logic [15:0] ew,
                            logic [15:0] pwt, bit is_last);
      int gap;
      req_tdata  <= {3'b000, pwt, ew, ty, lx};
      req_tlast  <= is_last;
      req_tvalid <= 1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_input(lx, ty, ew, pwt, is_last);
      gap = 0;
      if (!no_gaps && $urandom_range(0, 3) == 0)
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                           : $urandom_range(1, 3);
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Wait until every expected result is in, then let the pipeline settle
   task automatic drain();
      req_tvalid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_ADDR_W-1:0] addr, logic [31:0] value);
      csr_psel    <= 1;
      csr_penable <= 0;
      csr_pwrite  <= 1;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      sb.set_reg(addr, value);
      csr_psel    <= 0;
      csr_penable <= 0;
      csr_pwrite  <= 0;
   endtask

   task automatic set_config(logic [1:0] m, bit w, bit pw);
      csr_write({REG_MODE, 2'b00}, {30'd0, m});
      csr_write({REG_WEIGHT, 2'b00}, {31'd0, w});
      csr_write({REG_POSW, 2'b00}, {31'd0, pw});
   endtask

   // Random Q3.12 value leaning on the extremes
   function automatic logic [15:0] pick_q12();
      case ($urandom_range(0, 9))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'(ONE_Q12);
         3: return 16'(-$urandom_range(0, 8192));
         4: return 16'($urandom_range(0, 8192));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [12:0] pick_target();
      case ($urandom_range(0, 7))
         0: return 13'd0;
         1: return 13'(ONE_Q12);
         2: return 13'($urandom);
         default: return 13'($urandom_range(0, ONE_Q12));
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      int sent;
      int run_len;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: per-element corners with both weights used
      set_config(MODE_NONE, 1, 1);
      send_item(16'h8000, 13'd0,    16'h7FFF, 16'h8000, 0);
      send_item(16'h7FFF, 13'd4096, 16'h8000, 16'h7FFF, 1);
      send_item(16'h0000, 13'd8191, 16'h1000, 16'h1000, 0);
      send_item(16'hFFFF, 13'd2048, 16'hFFFF, 16'h0000, 0);
      send_item(16'h0001, 13'd5000, 16'h0000, 16'hFFFF, 0);
      send_item(16'h4000, 13'd1,    16'h2000, 16'h3000, 1);
      drain();
      // absent weights; register value masked, unused address ignored
      csr_write({REG_WEIGHT, 2'b00}, 32'hFFFF_FFFE);
      csr_write({REG_POSW, 2'b00}, 32'h0000_0002);
      csr_write(ADDR_NONE, 32'hFFFF_FFFF);
      send_item(16'h8000, 13'd4096, 16'h8000, 16'h8000, 0);
      send_item(16'h7FFF, 13'd0,    16'h8000, 16'h8000, 0);
      drain();
      // mean run, single-element run, then sum via masked write
      set_config(MODE_MEAN, 1, 1);
      send_item(16'h8000, 13'd0,    16'h7FFF, 16'h7FFF, 0);
      send_item(16'h1234, 13'd3000, 16'h8000, 16'h0800, 0);
      send_item(16'hF000, 13'd4096, 16'h1000, 16'h7FFF, 1);
      send_item(16'hC000, 13'd100,  16'hF000, 16'h1000, 1);
      drain();
      csr_write({REG_MODE, 2'b00}, 32'hFFFF_FFF6);
      send_item(16'h7FFF, 13'd0, 16'h7FFF, 16'h7FFF, 0);
      send_item(16'h8000, 13'd4096, 16'h7FFF, 16'h7FFF, 0);
      drain();
      // mode change mid-run keeps the accumulator
      csr_write({REG_MODE, 2'b00}, {30'd0, MODE_ALT});
      send_item(16'h2000, 13'd1000, 16'h1000, 16'h1000, 0);
      drain();
      csr_write({REG_MODE, 2'b00}, {30'd0, MODE_MEAN});
      send_item(16'hE000, 13'd8000, 16'h1000, 16'h1000, 1);
      drain();

      // Random phases under changing settings
      sent = 0;
      for (int phase = 0; sent < 1850; phase++) begin
         no_gaps = ($urandom_range(0, 3) == 0);
         no_stalls = ($urandom_range(0, 3) == 0);
         set_config(2'($urandom_range(0, 3)), $urandom_range(0, 1),
                    $urandom_range(0, 1));
         if (phase == 2) begin
            // receiver holds off while the sender keeps pushing
            set_config(MODE_NONE, 1, 1);
            no_gaps = 1;
            hold_cycles = 400;
         end
         for (int n = 0; n < 120; ) begin
            run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
            for (int k = 0; k < run_len; k++) begin
               send_item(pick_q12(), pick_target(), pick_q12(), pick_q12(),
                         (sb.mode == MODE_NONE) ? bit'($urandom_range(0, 1))
                                                : (k == run_len - 1));
            end
            n += run_len;
            sent += run_len;
         end
         drain();
      end
      no_gaps = 0;

      if (sb.mismatches == 0 && sb.pending.size() == 0) begin
         $display("PASS bce_with_logits_loss");
      end else begin
         $display("FAIL bce_with_logits_loss");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/bcel_pkg.sv
rtl/bcel_csr.sv
rtl/bcel_ctrl.sv
rtl/bcel_dp.sv
rtl/bce_with_logits_loss.sv
tb/sv/tb_top.sv
